@@ hw/rtl/svng_pkg.sv @@
// ----------------------------------------------------------------------------
// svng_pkg
// Shared codes, widths and control/status types of the smooth vertex normal
// generator.
// ----------------------------------------------------------------------------
package svng_pkg;

  // item commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_TRI   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam int IDX_W  = 10;
  localparam int POS_W  = 32;
  localparam int NRM_W  = 16;
  localparam int SUM_W  = 24;
  localparam int CNT_W  = 8;
  localparam int CNT_LW = 5;

  localparam logic [CNT_W-1:0] MAX_FACES = 8'd255;

  // last iteration index of each shared unit's counter
  localparam logic [CNT_LW-1:0] MUL_LAST  = 5'd6;
  localparam logic [CNT_LW-1:0] SQ_LAST   = 5'd3;
  localparam logic [CNT_LW-1:0] SQRT_LAST = 5'd30;
  localparam logic [CNT_LW-1:0] DIV_LAST  = 5'd16;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_CLEAR,
    OP_WRV,
    OP_PRD,
    OP_PLAT,
    OP_DIFF,
    OP_SCALE,
    OP_MUL,
    OP_NMAG,
    OP_NSHIFT,
    OP_NZERO,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_ARD,
    OP_AWR,
    OP_RRD,
    OP_LDSUM,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CNT_LW-1:0] cnt;
    logic [1:0]        k;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       a_ok;
    logic       tri_ok;
    logic       clr_last;
    logic       nrm_zero;
    logic       nrm_ok;
    logic       cnt_zero;
  } stat_t;

endpackage

@@ hw/rtl/svng_ram.sv @@
// ----------------------------------------------------------------------------
// svng_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module svng_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/svng_ctrl.sv @@
// ----------------------------------------------------------------------------
// svng_ctrl
// Sequencer of the vertex normal generator: handshakes, clearing pass and the
// step order of the shared cross product, normalize, sqrt and divide units.
// ----------------------------------------------------------------------------
module svng_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output svng_pkg::ctl_t ctl_o,
  input  svng_pkg::stat_t stat_i
);
  import svng_pkg::*;

  localparam logic [4:0] ST_CLEAR  = 5'd0;
  localparam logic [4:0] ST_IDLE   = 5'd1;
  localparam logic [4:0] ST_DISP   = 5'd2;
  localparam logic [4:0] ST_WRV    = 5'd3;
  localparam logic [4:0] ST_TRD    = 5'd4;
  localparam logic [4:0] ST_TLAT   = 5'd5;
  localparam logic [4:0] ST_DIFF   = 5'd6;
  localparam logic [4:0] ST_SCALE  = 5'd7;
  localparam logic [4:0] ST_MUL    = 5'd8;
  localparam logic [4:0] ST_NMAG   = 5'd9;
  localparam logic [4:0] ST_NSHIFT = 5'd10;
  localparam logic [4:0] ST_NZERO  = 5'd11;
  localparam logic [4:0] ST_SQ     = 5'd12;
  localparam logic [4:0] ST_SQI    = 5'd13;
  localparam logic [4:0] ST_SQRT   = 5'd14;
  localparam logic [4:0] ST_DIVI   = 5'd15;
  localparam logic [4:0] ST_DIV    = 5'd16;
  localparam logic [4:0] ST_DIVE   = 5'd17;
  localparam logic [4:0] ST_ARD    = 5'd18;
  localparam logic [4:0] ST_AWR    = 5'd19;
  localparam logic [4:0] ST_RRD    = 5'd20;
  localparam logic [4:0] ST_RLD    = 5'd21;
  localparam logic [4:0] ST_OUT    = 5'd22;

  logic [4:0]        state_q, state_d;
  logic [CNT_LW-1:0] cnt_q, cnt_d;
  logic [1:0]        k_q, k_d;
  logic              tri_q, tri_d;
  logic              out_valid_q, out_valid_d;
  op_e               op;

  // next state and datapath operation
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    tri_d       = tri_q;
    out_valid_d = out_valid_q & out_stall_i;
    op          = OP_NOP;
    unique case (state_q)
      ST_CLEAR: begin
        op = OP_CLEAR;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op      = OP_LOAD;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        k_d = 2'd0;
        priority if (stat_i.cmd == CMD_WRITE) begin
          state_d = stat_i.a_ok ? ST_WRV : ST_IDLE;
        end else if (stat_i.cmd == CMD_TRI) begin
          tri_d   = 1'b1;
          state_d = stat_i.tri_ok ? ST_TRD : ST_IDLE;
        end else if (stat_i.cmd == CMD_READ) begin
          tri_d   = 1'b0;
          state_d = stat_i.a_ok ? ST_RRD : ST_OUT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_WRV: begin
        op      = OP_WRV;
        state_d = ST_IDLE;
      end
      // fetch the three corner positions
      ST_TRD: begin
        op = OP_PRD;
        if (k_q == 2'd2) begin
          state_d = ST_TLAT;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      ST_TLAT: begin
        op      = OP_PLAT;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        op      = OP_DIFF;
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        op      = OP_SCALE;
        cnt_d   = '0;
        state_d = ST_MUL;
      end
      // cross product on the shared multiplier
      ST_MUL: begin
        op = OP_MUL;
        if (cnt_q == MUL_LAST) begin
          state_d = ST_NMAG;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_NMAG: begin
        op      = OP_NMAG;
        state_d = ST_NSHIFT;
      end
      // bring the largest magnitude into range
      ST_NSHIFT: begin
        priority if (stat_i.nrm_zero) begin
          state_d = ST_NZERO;
        end else if (stat_i.nrm_ok) begin
          cnt_d   = '0;
          state_d = ST_SQ;
        end else begin
          op = OP_NSHIFT;
        end
      end
      ST_NZERO: begin
        op      = OP_NZERO;
        k_d     = 2'd0;
        state_d = tri_q ? ST_ARD : ST_OUT;
      end
      ST_SQ: begin
        op = OP_SQ;
        if (cnt_q == SQ_LAST) begin
          state_d = ST_SQI;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_SQI: begin
        op      = OP_SQRT_INIT;
        cnt_d   = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        op = OP_SQRT_STEP;
        if (cnt_q == SQRT_LAST) begin
          k_d     = 2'd0;
          state_d = ST_DIVI;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      // one restoring divide per component
      ST_DIVI: begin
        op      = OP_DIV_INIT;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        op = OP_DIV_STEP;
        if (cnt_q == DIV_LAST) begin
          state_d = ST_DIVE;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_DIVE: begin
        op = OP_DIV_END;
        if (k_q == 2'd2) begin
          k_d     = 2'd0;
          state_d = tri_q ? ST_ARD : ST_OUT;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = ST_DIVI;
        end
      end
      // read-modify-write of each corner's sum and count
      ST_ARD: begin
        op      = OP_ARD;
        state_d = ST_AWR;
      end
      ST_AWR: begin
        op = OP_AWR;
        if (k_q == 2'd2) begin
          state_d = ST_IDLE;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = ST_ARD;
        end
      end
      ST_RRD: begin
        op      = OP_RRD;
        state_d = ST_RLD;
      end
      ST_RLD: begin
        op      = OP_LDSUM;
        state_d = stat_i.cnt_zero ? ST_OUT : ST_NMAG;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          op          = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      k_q         <= '0;
      tri_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      tri_q       <= tri_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign ctl_o       = '{op: op, cnt: cnt_q, k: k_q};
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/svng_dp.sv @@
// ----------------------------------------------------------------------------
// svng_dp
// Datapath of the vertex normal generator: vertex stores, edge scaling,
// shared multiplier, normalizing shifter, bit-serial square root and divider,
// face accumulation and the result register.
// ----------------------------------------------------------------------------
module svng_dp #(
  parameter int VERTICES = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  svng_pkg::ctl_t                     ctl_i,
  output svng_pkg::stat_t                    stat_o,
  input  logic [1:0]                         cmd_i,
  input  logic [svng_pkg::IDX_W-1:0]         index_a_i,
  input  logic [svng_pkg::IDX_W-1:0]         index_b_i,
  input  logic [svng_pkg::IDX_W-1:0]         index_c_i,
  input  logic signed [svng_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [svng_pkg::POS_W-1:0]  pos_y_i,
  input  logic signed [svng_pkg::POS_W-1:0]  pos_z_i,
  input  logic signed [svng_pkg::NRM_W-1:0]  init_nx_i,
  input  logic signed [svng_pkg::NRM_W-1:0]  init_ny_i,
  input  logic signed [svng_pkg::NRM_W-1:0]  init_nz_i,
  output logic [svng_pkg::IDX_W-1:0]         vertex_id_o,
  output logic signed [svng_pkg::NRM_W-1:0]  norm_x_o,
  output logic signed [svng_pkg::NRM_W-1:0]  norm_y_o,
  output logic signed [svng_pkg::NRM_W-1:0]  norm_z_o,
  output logic                               had_faces_o
);
  import svng_pkg::*;

  localparam int AW    = $clog2(VERTICES);
  localparam int POS_RW = 3 * POS_W;
  localparam int NRM_RW = 3 * NRM_W;
  localparam int SUM_RW = 3 * SUM_W + CNT_W;

  // captured item
  logic [1:0]              cmd_q;
  logic [IDX_W-1:0]        ia_q, ib_q, ic_q;
  logic signed [POS_W-1:0] px_q, py_q, pz_q;
  logic signed [NRM_W-1:0] nx_q, ny_q, nz_q;

  // working registers
  logic signed [POS_W-1:0] pp_q [3][3];
  logic signed [POS_W:0]   dd_q [6];
  logic signed [30:0]      d_q  [6];
  logic signed [61:0]      prod_q;
  logic signed [63:0]      vec_q [3];
  logic [61:0]             m_q [3];
  logic [2:0]              neg_q;
  logic [61:0]             sq_q;
  logic [61:0]             srem_q;
  logic [60:0]             sroot_q;
  logic [60:0]             sbit_q;
  logic [30:0]             drem_q;
  logic [16:0]             dlow_q;
  logic [16:0]             dq_q;
  logic signed [NRM_W-1:0] n_q [3];
  logic [AW-1:0]           clr_addr_q;

  // result register
  logic [IDX_W-1:0]        out_id_q;
  logic signed [NRM_W-1:0] out_n_q [3];
  logic                    out_had_q;

  // corner select and range checks
  logic [IDX_W-1:0] corner;
  logic             a_ok, b_ok, c_ok;

  always_comb begin
    unique case (ctl_i.k)
      2'd0:    corner = ia_q;
      2'd1:    corner = ib_q;
      default: corner = ic_q;
    endcase
  end

  assign a_ok = (32'(ia_q) < 32'(VERTICES));
  assign b_ok = (32'(ib_q) < 32'(VERTICES));
  assign c_ok = (32'(ic_q) < 32'(VERTICES));

  // vertex stores
  logic [POS_RW-1:0] pos_rdata;
  logic [NRM_RW-1:0] nrm_rdata;
  logic [SUM_RW-1:0] sum_rdata;
  logic              sum_we;
  logic [AW-1:0]     sum_waddr;
  logic [SUM_RW-1:0] sum_wdata;
  logic [SUM_RW-1:0] acc_wdata;

  svng_ram #(.WIDTH(POS_RW), .DEPTH(VERTICES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.op == OP_WRV),
    .waddr_i (AW'(ia_q)),
    .wdata_i ({pz_q, py_q, px_q}),
    .re_i    (ctl_i.op == OP_PRD),
    .raddr_i (AW'(corner)),
    .rdata_o (pos_rdata)
  );

  svng_ram #(.WIDTH(NRM_RW), .DEPTH(VERTICES)) u_nrm_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.op == OP_WRV),
    .waddr_i (AW'(ia_q)),
    .wdata_i ({nz_q, ny_q, nx_q}),
    .re_i    (ctl_i.op == OP_RRD),
    .raddr_i (AW'(ia_q)),
    .rdata_o (nrm_rdata)
  );

  svng_ram #(.WIDTH(SUM_RW), .DEPTH(VERTICES)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .re_i    ((ctl_i.op == OP_ARD) || (ctl_i.op == OP_RRD)),
    .raddr_i ((ctl_i.op == OP_ARD) ? AW'(corner) : AW'(ia_q)),
    .rdata_o (sum_rdata)
  );

  // fields of the read data
  logic signed [POS_W-1:0] pos_rd [3];
  logic signed [SUM_W-1:0] sum_rd [3];
  logic signed [SUM_W-1:0] sum_new [3];
  logic [CNT_W-1:0]        sum_cnt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_rd[i]  = pos_rdata[i*POS_W +: POS_W];
      sum_rd[i]  = sum_rdata[i*SUM_W +: SUM_W];
      sum_new[i] = sum_rd[i] + SUM_W'(n_q[i]);
    end
  end

  assign sum_cnt   = sum_rdata[3*SUM_W +: CNT_W];
  assign acc_wdata = {sum_cnt + 8'd1, sum_new[2], sum_new[1], sum_new[0]};

  // sum store write port
  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = AW'(ia_q);
    sum_wdata = '0;
    unique case (ctl_i.op)
      OP_CLEAR: begin
        sum_we    = 1'b1;
        sum_waddr = clr_addr_q;
      end
      OP_WRV: begin
        sum_we = 1'b1;
      end
      OP_AWR: begin
        sum_we    = (sum_cnt != MAX_FACES);
        sum_waddr = AW'(corner);
        sum_wdata = acc_wdata;
      end
      default: begin
      end
    endcase
  end

  // edge magnitudes and common scale
  logic [POS_W:0] dmag [6];
  logic [POS_W:0] dsc  [6];
  logic [1:0]     dsh;
  logic           any32, any31, any30;

  always_comb begin
    any32 = 1'b0;
    any31 = 1'b0;
    any30 = 1'b0;
    for (int j = 0; j < 6; j++) begin
      dmag[j] = dd_q[j][POS_W] ? (POS_W+1)'(-dd_q[j]) : (POS_W+1)'(dd_q[j]);
      any32   = any32 | dmag[j][32];
      any31   = any31 | dmag[j][31];
      any30   = any30 | dmag[j][30];
    end
    priority if (any32) dsh = 2'd3;
    else if (any31)     dsh = 2'd2;
    else if (any30)     dsh = 2'd1;
    else                dsh = 2'd0;
    for (int j = 0; j < 6; j++) begin
      dsc[j] = dmag[j] >> dsh;
    end
  end

  // shared multiplier operands
  logic signed [30:0] mul_a, mul_b;
  logic signed [61:0] mul_p;
  logic [1:0]         sidx;
  logic [2:0]         mj;

  assign sidx = (ctl_i.cnt[1:0] == 2'd3) ? 2'd0 : ctl_i.cnt[1:0];
  assign mj   = 3'(ctl_i.cnt - 5'd1);

  always_comb begin
    mul_a = d_q[0];
    mul_b = d_q[0];
    if (ctl_i.op == OP_SQ) begin
      mul_a = signed'({1'b0, m_q[sidx][29:0]});
      mul_b = signed'({1'b0, m_q[sidx][29:0]});
    end else begin
      unique case (ctl_i.cnt[2:0])
        3'd0: begin mul_a = d_q[1]; mul_b = d_q[5]; end
        3'd1: begin mul_a = d_q[2]; mul_b = d_q[4]; end
        3'd2: begin mul_a = d_q[2]; mul_b = d_q[3]; end
        3'd3: begin mul_a = d_q[0]; mul_b = d_q[5]; end
        3'd4: begin mul_a = d_q[0]; mul_b = d_q[4]; end
        3'd5: begin mul_a = d_q[1]; mul_b = d_q[3]; end
        default: begin end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  // largest magnitude for the normalizing shift
  logic [61:0] big01, big;
  logic        nrm_zero, nrm_ok;

  assign big01    = (m_q[0] > m_q[1]) ? m_q[0] : m_q[1];
  assign big      = (big01 > m_q[2]) ? big01 : m_q[2];
  assign nrm_zero = (big == '0);
  assign nrm_ok   = (big[61:30] == '0) && big[29];

  // square root step
  logic [61:0] sq_t;
  assign sq_t = {1'b0, sroot_q} + {1'b0, sbit_q};

  // divide step
  logic [30:0] len;
  logic [45:0] div_num;
  logic [31:0] div_r2, div_sub;
  logic        div_ge;
  logic [14:0] div_sat;

  assign len     = sroot_q[30:0];
  assign div_num = {1'b0, m_q[ctl_i.k][29:0], 15'd0} + {16'd0, len[30:1]};
  assign div_r2  = {drem_q, dlow_q[16]};
  assign div_ge  = (div_r2 >= {1'b0, len});
  assign div_sub = div_r2 - {1'b0, len};
  assign div_sat = (dq_q > 17'd32767) ? 15'h7fff : dq_q[14:0];

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      OP_LOAD: begin
        cmd_q <= cmd_i;
        ia_q  <= index_a_i;
        ib_q  <= index_b_i;
        ic_q  <= index_c_i;
        px_q  <= pos_x_i;
        py_q  <= pos_y_i;
        pz_q  <= pos_z_i;
        nx_q  <= init_nx_i;
        ny_q  <= init_ny_i;
        nz_q  <= init_nz_i;
      end
      OP_PRD: begin
        if (ctl_i.k != 2'd0) begin
          for (int i = 0; i < 3; i++) pp_q[ctl_i.k - 2'd1][i] <= pos_rd[i];
        end
      end
      OP_PLAT: begin
        for (int i = 0; i < 3; i++) pp_q[2][i] <= pos_rd[i];
      end
      OP_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          dd_q[i]   <= (POS_W+1)'(pp_q[2][i]) - (POS_W+1)'(pp_q[0][i]);
          dd_q[i+3] <= (POS_W+1)'(pp_q[1][i]) - (POS_W+1)'(pp_q[0][i]);
        end
      end
      OP_SCALE: begin
        for (int j = 0; j < 6; j++) begin
          d_q[j] <= dd_q[j][POS_W] ? -signed'(dsc[j][30:0]) : signed'(dsc[j][30:0]);
        end
      end
      OP_MUL: begin
        prod_q <= mul_p;
        if (ctl_i.cnt != '0) begin
          if (!mj[0]) vec_q[mj[2:1]] <= 64'(prod_q);
          else        vec_q[mj[2:1]] <= vec_q[mj[2:1]] - 64'(prod_q);
        end
      end
      OP_LDSUM: begin
        for (int i = 0; i < 3; i++) vec_q[i] <= 64'(sum_rd[i]);
      end
      OP_NMAG: begin
        for (int i = 0; i < 3; i++) begin
          m_q[i]   <= vec_q[i][63] ? 62'(-vec_q[i]) : 62'(vec_q[i]);
          neg_q[i] <= vec_q[i][63];
        end
      end
      OP_NSHIFT: begin
        for (int i = 0; i < 3; i++) begin
          priority if (big[61:34] != '0) m_q[i] <= m_q[i] >> 4;
          else if (big[61:30] != '0)     m_q[i] <= m_q[i] >> 1;
          else if (big[29:25] == '0)     m_q[i] <= m_q[i] << 4;
          else                           m_q[i] <= m_q[i] << 1;
        end
      end
      OP_NZERO: begin
        for (int i = 0; i < 3; i++) n_q[i] <= '0;
      end
      OP_SQ: begin
        prod_q <= mul_p;
        if (ctl_i.cnt != '0) begin
          sq_q <= ((ctl_i.cnt == 5'd1) ? 62'd0 : sq_q) + unsigned'(prod_q);
        end
      end
      OP_SQRT_INIT: begin
        srem_q  <= sq_q;
        sroot_q <= '0;
        sbit_q  <= {1'b1, 60'd0};
      end
      OP_SQRT_STEP: begin
        if (srem_q >= sq_t) begin
          srem_q  <= srem_q - sq_t;
          sroot_q <= (sroot_q >> 1) + sbit_q;
        end else begin
          sroot_q <= sroot_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      OP_DIV_INIT: begin
        drem_q <= {2'b00, div_num[45:17]};
        dlow_q <= div_num[16:0];
        dq_q   <= '0;
      end
      OP_DIV_STEP: begin
        drem_q <= div_ge ? div_sub[30:0] : div_r2[30:0];
        dq_q   <= {dq_q[15:0], div_ge};
        dlow_q <= {dlow_q[15:0], 1'b0};
      end
      OP_DIV_END: begin
        n_q[ctl_i.k] <= neg_q[ctl_i.k] ? -signed'({1'b0, div_sat}) : signed'({1'b0, div_sat});
      end
      OP_OUT: begin
        out_id_q <= ia_q;
        priority if (!a_ok) begin
          for (int i = 0; i < 3; i++) out_n_q[i] <= '0;
          out_had_q <= 1'b0;
        end else if (sum_cnt == '0) begin
          for (int i = 0; i < 3; i++) out_n_q[i] <= nrm_rdata[i*NRM_W +: NRM_W];
          out_had_q <= 1'b0;
        end else begin
          for (int i = 0; i < 3; i++) out_n_q[i] <= n_q[i];
          out_had_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // clearing pass address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (ctl_i.op == OP_CLEAR) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // status to the controller
  assign stat_o = '{
    cmd:      cmd_q,
    a_ok:     a_ok,
    tri_ok:   a_ok && b_ok && c_ok,
    clr_last: (clr_addr_q == AW'(VERTICES - 1)),
    nrm_zero: nrm_zero,
    nrm_ok:   nrm_ok,
    cnt_zero: (sum_cnt == '0)
  };

  assign vertex_id_o = out_id_q;
  assign norm_x_o    = out_n_q[0];
  assign norm_y_o    = out_n_q[1];
  assign norm_z_o    = out_n_q[2];
  assign had_faces_o = out_had_q;

endmodule

@@ hw/rtl/smooth_vertex_normal_gen.sv @@
// ----------------------------------------------------------------------------
// smooth_vertex_normal_gen
// Smooth vertex normal generator. After reset the block clears the normal
// sums and face counts of all VERTICES entries and holds in_stall_o high.
// A triangle whose face normal is zero skips the square root and divides,
// as does a read of a vertex whose sum is zero; a read of a vertex without
// faces or of an out of range vertex skips all arithmetic.
// A read may take longer while the previous result still waits at the output.
// The time an item takes is set by the 31-step bit-serial square root and
// the three restoring divides of the normalizer, by the normalizing shifter
// (one or four bit positions a cycle), by the six products of the cross
// product and the three squares of the length on the one shared 31x31
// multiplier, and by the three read-modify-write passes on the sum store.
// Items are taken one at a time; a finished result waits in the output
// register while the next item runs.
// ----------------------------------------------------------------------------
module smooth_vertex_normal_gen #(
  parameter int VERTICES = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         cmd_i,
  input  logic [svng_pkg::IDX_W-1:0]         index_a_i,
  input  logic [svng_pkg::IDX_W-1:0]         index_b_i,
  input  logic [svng_pkg::IDX_W-1:0]         index_c_i,
  input  logic signed [svng_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [svng_pkg::POS_W-1:0]  pos_y_i,
  input  logic signed [svng_pkg::POS_W-1:0]  pos_z_i,
  input  logic signed [svng_pkg::NRM_W-1:0]  init_nx_i,
  input  logic signed [svng_pkg::NRM_W-1:0]  init_ny_i,
  input  logic signed [svng_pkg::NRM_W-1:0]  init_nz_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [svng_pkg::IDX_W-1:0]         vertex_id_o,
  output logic signed [svng_pkg::NRM_W-1:0]  norm_x_o,
  output logic signed [svng_pkg::NRM_W-1:0]  norm_y_o,
  output logic signed [svng_pkg::NRM_W-1:0]  norm_z_o,
  output logic                               had_faces_o
);
  import svng_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  // sequencer
  svng_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl),
    .stat_i      (stat)
  );

  // stores and arithmetic
  svng_dp #(.VERTICES(VERTICES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .cmd_i       (cmd_i),
    .index_a_i   (index_a_i),
    .index_b_i   (index_b_i),
    .index_c_i   (index_c_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .init_nx_i   (init_nx_i),
    .init_ny_i   (init_ny_i),
    .init_nz_i   (init_nz_i),
    .vertex_id_o (vertex_id_o),
    .norm_x_o    (norm_x_o),
    .norm_y_o    (norm_y_o),
    .norm_z_o    (norm_z_o),
    .had_faces_o (had_faces_o)
  );

endmodule

@@ tb/smooth_vertex_normal_gen_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smooth_vertex_normal_gen_test
// Self-checking bench for the smooth vertex normal generator. Vertex writes,
// triangles and reads are driven with random gaps and output stalls. Each
// read is predicted by a normal accumulator kept in a small scoreboard class
// and compared field by field with the result the block returns.
// ----------------------------------------------------------------------------
module smooth_vertex_normal_gen_test;
  import svng_pkg::*;

  localparam int NVTX      = 1024;
  localparam int DOG_LIMIT = 6000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]               cmd;
    logic [IDX_W-1:0]         a, b, c;
    logic signed [POS_W-1:0]  p [3];
    logic signed [NRM_W-1:0]  n [3];
  } vtx_item_t;

  typedef struct {
    logic [IDX_W-1:0]         id;
    logic signed [NRM_W-1:0]  n [3];
    logic                     had;
  } normal_res_t;

  // normal accumulator and store of expected read results
  class normal_scoreboard;
    int             pos [NVTX][3];
    shortint        orig [NVTX][3];
    int             sum [NVTX][3];
    byte unsigned   cnt [NVTX];
    normal_res_t    pending_q [$];
    int             errors;

    function new();
      foreach (cnt[i]) begin
        cnt[i] = '0;
        for (int k = 0; k < 3; k++) begin
          pos[i][k] = 0; orig[i][k] = '0; sum[i][k] = 0;
        end
      end
      errors = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned s);
      longint unsigned r, bt;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > s) bt = bt >> 2;
      while (bt != 0) begin
        if (s >= r + bt) begin
          s = s - (r + bt);
          r = (r >> 1) + bt;
        end else begin
          r = r >> 1;
        end
        bt = bt >> 2;
      end
      return r;
    endfunction

    // scale to [2^29, 2^30), then divide by the length with rounding
    function void unit_vec(input longint v [3], output int o [3]);
      longint unsigned m [3];
      longint unsigned big, len, q;
      bit neg [3];
      for (int i = 0; i < 3; i++) begin
        neg[i] = v[i] < 0;
        m[i] = neg[i] ? 64'(-v[i]) : 64'(v[i]);
      end
      big = m[0];
      if (m[1] > big) big = m[1];
      if (m[2] > big) big = m[2];
      if (big == 0) begin
        o[0] = 0; o[1] = 0; o[2] = 0;
        return;
      end
      while (big >= (64'd1 << 30)) begin
        big = big >> 1;
        for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (big < (64'd1 << 29)) begin
        big = big << 1;
        for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << 15) + (len >> 1)) / len;
        if (q > 32767) q = 32767;
        o[i] = neg[i] ? -int'(q) : int'(q);
      end
    endfunction

    // cross product (p2-p0)x(p1-p0) with edges halved until below 2^30
    function void face_normal(int a, int b, int c, output int o [3]);
      longint d [6];
      longint unsigned m [6];
      longint unsigned big;
      longint cr [3];
      bit neg [6];
      big = 0;
      for (int i = 0; i < 3; i++) begin
        d[i]     = longint'(pos[c][i]) - longint'(pos[a][i]);
        d[i + 3] = longint'(pos[b][i]) - longint'(pos[a][i]);
      end
      for (int i = 0; i < 6; i++) begin
        neg[i] = d[i] < 0;
        m[i] = neg[i] ? 64'(-d[i]) : 64'(d[i]);
        if (m[i] > big) big = m[i];
      end
      while (big >= (64'd1 << 30)) begin
        big = big >> 1;
        for (int i = 0; i < 6; i++) m[i] = m[i] >> 1;
      end
      for (int i = 0; i < 6; i++) d[i] = neg[i] ? -longint'(m[i]) : longint'(m[i]);
      cr[0] = d[1] * d[5] - d[2] * d[4];
      cr[1] = d[2] * d[3] - d[0] * d[5];
      cr[2] = d[0] * d[4] - d[1] * d[3];
      unit_vec(cr, o);
    endfunction

    function void add_face(int v, int n [3]);
      if (cnt[v] >= MAX_FACES) return;
      cnt[v]++;
      for (int i = 0; i < 3; i++) sum[v][i] += n[i];
    endfunction

    // accepted input item
    function void note_item(vtx_item_t it);
      int fn [3];
      longint s [3];
      normal_res_t r;
      case (it.cmd)
        CMD_WRITE: begin
          for (int i = 0; i < 3; i++) begin
            pos[it.a][i] = it.p[i];
            orig[it.a][i] = it.n[i];
            sum[it.a][i] = 0;
          end
          cnt[it.a] = '0;
        end
        CMD_TRI: begin
          face_normal(it.a, it.b, it.c, fn);
          add_face(it.a, fn);
          add_face(it.b, fn);
          add_face(it.c, fn);
        end
        CMD_READ: begin
          r.id = it.a;
          if (cnt[it.a] == 0) begin
            for (int i = 0; i < 3; i++) r.n[i] = orig[it.a][i];
            r.had = 1'b0;
          end else begin
            for (int i = 0; i < 3; i++) s[i] = sum[it.a][i];
            unit_vec(s, fn);
            for (int i = 0; i < 3; i++) r.n[i] = fn[i][15:0];
            r.had = 1'b1;
          end
          pending_q.insert(pending_q.size(), r);
        end
        default: ;
      endcase
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("mismatch %0s: got %0d expected %0d", what, got, want);
    endtask

    // accepted result against the oldest expectation
    task check_result(normal_res_t got);
      normal_res_t w;
      if (pending_q.size() == 0) begin
        report("unexpected result, vertex", got.id, -1);
        return;
      end
      w = pending_q.pop_front();
      if (got.id !== w.id) report("vertex_id", got.id, w.id);
      if (got.n[0] !== w.n[0]) report("norm_x", got.n[0], w.n[0]);
      if (got.n[1] !== w.n[1]) report("norm_y", got.n[1], w.n[1]);
      if (got.n[2] !== w.n[2]) report("norm_z", got.n[2], w.n[2]);
      if (got.had !== w.had) report("had_faces", got.had, w.had);
    endtask
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               cmd_i = '0;
  logic [IDX_W-1:0]         index_a_i = '0, index_b_i = '0, index_c_i = '0;
  logic signed [POS_W-1:0]  pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [NRM_W-1:0]  init_nx_i = '0, init_ny_i = '0, init_nz_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [IDX_W-1:0]         vertex_id_o;
  logic signed [NRM_W-1:0]  norm_x_o, norm_y_o, norm_z_o;
  logic                     had_faces_o;

  normal_scoreboard sb = new();
  bit  idle_on = 1'b1;
  bit  written [NVTX];
  int  wr_list [$];
  int  dog = 0;

  smooth_vertex_normal_gen u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // drive one item, note it when accepted
  task automatic send_item(vtx_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= it.cmd;
    index_a_i <= it.a;
    index_b_i <= it.b;
    index_c_i <= it.c;
    pos_x_i <= it.p[0];
    pos_y_i <= it.p[1];
    pos_z_i <= it.p[2];
    init_nx_i <= it.n[0];
    init_ny_i <= it.n[1];
    init_nz_i <= it.n[2];
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    if (it.cmd == CMD_WRITE && !written[it.a]) begin
      written[it.a] = 1'b1;
      wr_list.insert(wr_list.size(), int'(it.a));
    end
  endtask

  function automatic vtx_item_t mk(logic [1:0] cmd, int a, int b, int c);
    vtx_item_t it;
    it.cmd = cmd;
    it.a = IDX_W'(a); it.b = IDX_W'(b); it.c = IDX_W'(c);
    for (int i = 0; i < 3; i++) begin
      it.p[i] = $urandom;
      it.n[i] = NRM_W'($urandom);
    end
    return it;
  endfunction

  task automatic write_vtx(int a, int x, int y, int z, int nx, int ny, int nz);
    vtx_item_t it;
    it = mk(CMD_WRITE, a, $urandom_range(0, 1023), $urandom_range(0, 1023));
    it.p[0] = x; it.p[1] = y; it.p[2] = z;
    it.n[0] = NRM_W'(nx); it.n[1] = NRM_W'(ny); it.n[2] = NRM_W'(nz);
    send_item(it);
  endtask

  task automatic write_rand(int a);
    vtx_item_t it;
    it = mk(CMD_WRITE, a, $urandom_range(0, 1023), $urandom_range(0, 1023));
    // small coordinates now and then
    if ($urandom_range(0, 2) == 0)
      for (int i = 0; i < 3; i++) it.p[i] = $signed($urandom_range(0, 2000)) - 1000;
    send_item(it);
  endtask

  function automatic int pick_written();
    return wr_list[$urandom_range(0, wr_list.size() - 1)];
  endfunction

  // result side: random stall before each result
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = idle_on ? $urandom_range(0, 18) : 0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // compare accepted results
  always @(posedge clk_i) begin
    normal_res_t r;
    if (out_valid_o && !out_stall_i) begin
      r.id = vertex_id_o;
      r.n[0] = norm_x_o; r.n[1] = norm_y_o; r.n[2] = norm_z_o;
      r.had = had_faces_o;
      sb.check_result(r);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) dog <= 0;
    else dog <= dog + 1;
    if (dog >= DOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int seg_len, kind, base, v, w, x, cnt;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, degenerate faces, unused command
    write_vtx(0, 0, 0, 0, 32767, -32768, 0);
    write_vtx(1, 32'h7fffffff, 0, 32'h80000000, -1, 1, 32767);
    write_vtx(2, 0, 32'h7fffffff, 32'h80000000, -32768, -32768, -32768);
    write_vtx(1023, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
    write_vtx(3, 65536, 0, 0, 100, -100, 7);
    write_vtx(4, 0, 65536, 0, 0, 32767, 0);
    send_item(mk(CMD_READ, 0, 5, 9));
    send_item(mk(CMD_READ, 1023, 0, 0));
    send_item(mk(CMD_TRI, 0, 1, 2));
    send_item(mk(CMD_READ, 0, 0, 0));
    send_item(mk(CMD_READ, 1, 0, 0));
    send_item(mk(CMD_TRI, 3, 3, 4));
    send_item(mk(CMD_READ, 3, 0, 0));
    send_item(mk(CMD_TRI, 0, 3, 4));
    send_item(mk(CMD_READ, 4, 0, 0));
    send_item(mk(CMD_TRI, 1023, 1, 2));
    send_item(mk(CMD_READ, 1023, 0, 0));
    send_item(mk(CMD_UNUSED, 1023, 1023, 1023));
    send_item(mk(CMD_READ, 2, 0, 0));
    write_vtx(0, -1, -1, -1, 1, 1, 1);
    send_item(mk(CMD_READ, 0, 0, 0));

    // random segments
    cnt = 0;
    while (cnt < 1950) begin
      kind = $urandom_range(0, 9);
      idle_on = $urandom_range(0, 3) != 0;
      if (kind == 0) begin
        // saturate one corner, then let its neighbors keep taking faces
        v = $urandom_range(0, 1023);
        w = $urandom_range(0, 1023);
        x = $urandom_range(0, 1023);
        write_rand(v); write_rand(w); write_rand(x);
        for (int i = 0; i < 3; i++) send_item(mk(CMD_TRI, v, w, x));
        for (int i = 0; i < 86; i++) send_item(mk(CMD_TRI, v, v, v));
        send_item(mk(CMD_TRI, w, v, x));
        send_item(mk(CMD_READ, v, 0, 0));
        send_item(mk(CMD_READ, w, 0, 0));
        cnt += 96;
      end else begin
        seg_len = $urandom_range(30, 120);
        base = $urandom_range(0, 1019);
        if (kind < 5)
          for (int i = 0; i < 4; i++) write_rand(base + i);
        for (int i = 0; i < seg_len; i++) begin
          int r;
          int ia, ib, ic;
          r = $urandom_range(0, 99);
          if (kind < 5) begin
            ia = base + $urandom_range(0, 3);
            ib = base + $urandom_range(0, 3);
            ic = base + $urandom_range(0, 3);
          end else begin
            ia = pick_written(); ib = pick_written(); ic = pick_written();
          end
          if (r < 3)
            send_item(mk(CMD_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 1023)));
          else if (r < (kind < 5 ? 8 : 25))
            write_rand(kind < 5 ? ia : $urandom_range(0, 1023));
          else if (r < 65)
            send_item(mk(CMD_TRI, ia, ib, ic));
          else
            send_item(mk(CMD_READ, ia, $urandom_range(0, 1023), $urandom_range(0, 1023)));
        end
        cnt += seg_len;
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/svng_pkg.sv
hw/rtl/svng_ram.sv
hw/rtl/svng_ctrl.sv
hw/rtl/svng_dp.sv
hw/rtl/smooth_vertex_normal_gen.sv
tb/smooth_vertex_normal_gen_test.sv
